[hdl/wsti_pkg.sv]
// shared types, codes and helpers of the wind speed table interpolator
`default_nettype none

package wsti_pkg;

  // one breakpoint as stored in the table
  typedef struct packed {
    logic [31:0] bp_time;
    logic [31:0] bp_speed;
  } point_t;

  // item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TABLE_MODE   = 2'd0;
  localparam logic [1:0] REG_STEADY_SPEED = 2'd1;
  localparam logic [1:0] REG_CYCLE_ENABLE = 2'd2;
  localparam logic [1:0] REG_POINT_COUNT  = 2'd3;

  // width of the shared adder and last step of a bit-serial pass
  localparam int unsigned ALU_W     = 35;
  localparam logic [5:0]  STEP_LAST = 6'd32;

  // sign extend a q16.16 word to adder width
  function automatic logic [ALU_W-1:0] sext_alu(input logic [31:0] v);
    return {{(ALU_W - 32){v[31]}}, v};
  endfunction

endpackage

`default_nettype wire

[hdl/wsti_table.sv]
// breakpoint table memory with one write port and one registered read port
`default_nettype none

module wsti_table #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire wsti_pkg::point_t wr_point_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output wsti_pkg::point_t     rd_point_o
);

  wsti_pkg::point_t mem_q [DEPTH];
  wsti_pkg::point_t rd_point_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_point_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_point_q <= mem_q[rd_addr_i];
  end

  assign rd_point_o = rd_point_q;

endmodule

`default_nettype wire

[hdl/wind_speed_table_interpolator_core.sv]
// Wind speed table interpolator: breakpoint table, query sequencer and shared adder.
//
// Channels: the input channel carries write items (command 0) that load one
// breakpoint and query items (command 1) that ask for the speed at a time.
// An item is taken when in_valid_i is high and in_stall_o is low; in_stall_o
// is high while a query is being worked on. Each query gives one result item on
// out_valid_o/out_stall_i; a write gives none. Configuration goes over the
// cfg channel (index, data), which is always ready; write it only while idle.
// Writes are accepted back to back. A steady-mode or empty-table query goes
// straight to its result, a one-point table reads its single breakpoint, and
// a time clamped at either table end needs the last and first breakpoints. An
// interpolated query also searches the table linearly and then interpolates;
// a wrapped time adds a modulo pass before the clamp and the search.
// One 35-bit adder does the 33-step multiply, the 33-step divide and the
// 33-step modulo one bit per cycle, and the linear table search reads one
// breakpoint per cycle from the memory port.
// Reset clears the configuration to zero and drops any pending item and
// result; table contents are undefined until written. A stalled result holds
// in the output register while the next item can already be accepted; a
// finished query waits for that register to free up before returning idle.
`default_nettype none

module wind_speed_table_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output wire logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // input item channel
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               in_command_i,
  input  wire logic [5:0]         in_point_index_i,
  input  wire logic signed [31:0] in_point_time_i,
  input  wire logic signed [31:0] in_point_speed_i,
  input  wire logic signed [31:0] in_query_time_i,
  // result item channel
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] out_wind_speed_o,
  output      logic               out_status_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned AL = wsti_pkg::ALU_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_LAST, ST_RD_FIRST, ST_MOD, ST_CHECK, ST_SEARCH, ST_DIFF, ST_ABS,
    ST_NUM, ST_DEN, ST_MUL, ST_DIV, ST_RND, ST_QADD, ST_FIN, ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic               table_mode_q;
  logic signed [31:0] steady_q;
  logic               cycle_q;
  logic [6:0]         count_q;

  // output registers
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_speed_q, out_speed_d;
  logic               out_status_q, out_status_d;

  // datapath registers
  logic signed [31:0] tin_q, tin_d;
  logic signed [31:0] dur_q, dur_d;
  logic [31:0]        slast_q, slast_d;
  logic signed [31:0] t_q, t_d;
  logic signed [31:0] tl_q, tl_d;
  logic [31:0]        sl_q, sl_d;
  logic signed [31:0] tr_q, tr_d;
  logic [31:0]        sr_q, sr_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      last_q, last_d;
  logic [33:0]        acc_q, acc_d;
  logic [32:0]        lo_q, lo_d;
  logic [32:0]        den_q, den_d;
  logic [32:0]        mag_q, mag_d;
  logic               neg_q, neg_d;
  logic               rnd_q, rnd_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [31:0]        res_q, res_d;
  logic               res_status_q, res_status_d;

  // table ports
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  wsti_pkg::point_t   wr_point;
  wsti_pkg::point_t   rd_point;

  // shared adder
  logic [AL-1:0]      alu_a, alu_b, alu_res;
  logic               alu_inv, alu_cin;

  logic [AW-1:0]      last_idx;
  logic [33:0]        rem_sh;
  logic               rem_ge;
  logic [33:0]        mul_sum;

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign out_wind_speed_o = out_speed_q;
  assign out_status_o     = out_status_q;

  // index of the last breakpoint in use, point count clamped to the depth
  assign last_idx = (32'(count_q) > TABLE_DEPTH) ? AW'(TABLE_DEPTH - 1)
                                                 : AW'(count_q - 7'd1);

  assign wr_point.bp_time  = in_point_time_i;
  assign wr_point.bp_speed = in_point_speed_i;

  wsti_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (AW'(in_point_index_i)),
    .wr_point_i (wr_point),
    .rd_addr_i  (rd_addr),
    .rd_point_o (rd_point)
  );

  // one restoring divide step, shared by modulo and division
  assign rem_sh = {acc_q[32:0], lo_q[32]};
  assign rem_ge = ~alu_res[AL-1];

  // one shift-and-add multiply step
  assign mul_sum = lo_q[0] ? alu_res[33:0] : acc_q;

  // operand selection of the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    case (state_q)
      ST_MOD, ST_DIV: begin
        alu_a   = AL'(rem_sh);
        alu_b   = AL'(den_q);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_DIFF: begin
        alu_a   = wsti_pkg::sext_alu(sr_q);
        alu_b   = wsti_pkg::sext_alu(sl_q);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_ABS: begin
        alu_b   = {acc_q[33], acc_q};
        alu_inv = neg_q;
        alu_cin = neg_q;
      end
      ST_NUM: begin
        alu_a   = wsti_pkg::sext_alu(t_q);
        alu_b   = wsti_pkg::sext_alu(tl_q);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_DEN: begin
        alu_a   = wsti_pkg::sext_alu(tr_q);
        alu_b   = wsti_pkg::sext_alu(tl_q);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_MUL: begin
        alu_a = AL'(acc_q);
        alu_b = AL'(mag_q);
      end
      ST_RND: begin
        alu_a   = AL'({acc_q[32:0], 1'b0});
        alu_b   = AL'(den_q);
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      ST_QADD: begin
        alu_a   = AL'(lo_q);
        alu_cin = rnd_q;
      end
      ST_FIN: begin
        alu_a   = wsti_pkg::sext_alu(sl_q);
        alu_b   = AL'(lo_q);
        alu_inv = neg_q;
        alu_cin = neg_q;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_a + (alu_inv ? ~alu_b : alu_b) + AL'(alu_cin);

  // query sequencer
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    out_speed_d  = out_speed_q;
    out_status_d = out_status_q;
    tin_d        = tin_q;
    dur_d        = dur_q;
    slast_d      = slast_q;
    t_d          = t_q;
    tl_d         = tl_q;
    sl_d         = sl_q;
    tr_d         = tr_q;
    sr_d         = sr_q;
    idx_d        = idx_q;
    last_d       = last_q;
    acc_d        = acc_q;
    lo_d         = lo_q;
    den_d        = den_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    rnd_d        = rnd_q;
    cnt_d        = cnt_q;
    res_d        = res_q;
    res_status_d = res_status_q;
    wr_en        = 1'b0;
    rd_addr      = '0;

    // result taken by the receiver
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        rd_addr = last_idx;
        if (in_valid_i) begin
          if (in_command_i == wsti_pkg::CMD_WRITE) begin
            wr_en = (32'(in_point_index_i) < TABLE_DEPTH);
          end else begin
            tin_d = in_query_time_i;
            if (!table_mode_q) begin
              res_d        = steady_q;
              res_status_d = wsti_pkg::STATUS_OK;
              state_d      = ST_EMIT;
            end else if (count_q == '0) begin
              res_d        = '0;
              res_status_d = wsti_pkg::STATUS_EMPTY;
              state_d      = ST_EMIT;
            end else begin
              last_d  = last_idx;
              state_d = ST_RD_LAST;
            end
          end
        end
      end
      ST_RD_LAST: begin
        // last breakpoint gives the duration
        dur_d   = rd_point.bp_time;
        slast_d = rd_point.bp_speed;
        rd_addr = '0;
        if (last_q == '0) begin
          res_d        = rd_point.bp_speed;
          res_status_d = wsti_pkg::STATUS_OK;
          state_d      = ST_EMIT;
        end else begin
          state_d = ST_RD_FIRST;
        end
      end
      ST_RD_FIRST: begin
        // first breakpoint, then bring the query time into range
        tl_d = rd_point.bp_time;
        sl_d = rd_point.bp_speed;
        if (tin_q < 0 || dur_q <= 0) begin
          t_d     = '0;
          state_d = ST_CHECK;
        end else if (tin_q <= dur_q) begin
          t_d     = tin_q;
          state_d = ST_CHECK;
        end else if (!cycle_q) begin
          t_d     = dur_q;
          state_d = ST_CHECK;
        end else begin
          acc_d   = '0;
          lo_d    = {1'b0, tin_q};
          den_d   = {1'b0, dur_q};
          cnt_d   = '0;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        acc_d = rem_ge ? alu_res[33:0] : rem_sh;
        lo_d  = {lo_q[31:0], rem_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == wsti_pkg::STEP_LAST) begin
          t_d     = acc_d[31:0];
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // clamp at either end of the table
        if (t_q <= tl_q) begin
          res_d        = sl_q;
          res_status_d = wsti_pkg::STATUS_OK;
          state_d      = ST_EMIT;
        end else if (t_q >= dur_q) begin
          res_d        = slast_q;
          res_status_d = wsti_pkg::STATUS_OK;
          state_d      = ST_EMIT;
        end else begin
          rd_addr = AW'(1);
          idx_d   = AW'(1);
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // one breakpoint per cycle, next address already issued
        rd_addr = idx_q + AW'(1);
        if ($signed(rd_point.bp_time) > t_q || idx_q == last_q) begin
          tr_d    = rd_point.bp_time;
          sr_d    = rd_point.bp_speed;
          state_d = ST_DIFF;
        end else begin
          tl_d  = rd_point.bp_time;
          sl_d  = rd_point.bp_speed;
          idx_d = idx_q + AW'(1);
        end
      end
      ST_DIFF: begin
        acc_d   = alu_res[33:0];
        neg_d   = alu_res[AL-1];
        state_d = ST_ABS;
      end
      ST_ABS: begin
        mag_d   = alu_res[32:0];
        state_d = ST_NUM;
      end
      ST_NUM: begin
        lo_d    = alu_res[32:0];
        acc_d   = '0;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        den_d   = alu_res[32:0];
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d = {1'b0, mul_sum[33:1]};
        lo_d  = {mul_sum[0], lo_q[32:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == wsti_pkg::STEP_LAST) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        acc_d = rem_ge ? alu_res[33:0] : rem_sh;
        lo_d  = {lo_q[31:0], rem_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == wsti_pkg::STEP_LAST) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        // round half away from zero on the magnitude
        rnd_d   = ~alu_res[AL-1];
        state_d = ST_QADD;
      end
      ST_QADD: begin
        lo_d    = alu_res[32:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        res_d        = alu_res[31:0];
        res_status_d = wsti_pkg::STATUS_OK;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_speed_d  = res_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, configuration and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      table_mode_q <= 1'b0;
      steady_q     <= '0;
      cycle_q      <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_speed_q  <= '0;
      out_status_q <= wsti_pkg::STATUS_OK;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      out_speed_q  <= out_speed_d;
      out_status_q <= out_status_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          wsti_pkg::REG_TABLE_MODE:   table_mode_q <= cfg_data_i[0];
          wsti_pkg::REG_STEADY_SPEED: steady_q     <= cfg_data_i;
          wsti_pkg::REG_CYCLE_ENABLE: cycle_q      <= cfg_data_i[0];
          wsti_pkg::REG_POINT_COUNT:  count_q      <= cfg_data_i[6:0];
          default:                    count_q      <= count_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    tin_q        <= tin_d;
    dur_q        <= dur_d;
    slast_q      <= slast_d;
    t_q          <= t_d;
    tl_q         <= tl_d;
    sl_q         <= sl_d;
    tr_q         <= tr_d;
    sr_q         <= sr_d;
    idx_q        <= idx_d;
    last_q       <= last_d;
    acc_q        <= acc_d;
    lo_q         <= lo_d;
    den_q        <= den_d;
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    rnd_q        <= rnd_d;
    cnt_q        <= cnt_d;
    res_q        <= res_d;
    res_status_q <= res_status_d;
  end

  // the search never runs past the last breakpoint in use
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (idx_q <= last_q))
    else $error("table search index beyond last breakpoint");

  // the partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD || state_q == ST_DIV) |-> (acc_q < 34'(den_q)))
    else $error("divide remainder out of range");

  // an empty-table status always comes with a zero speed
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == wsti_pkg::STATUS_EMPTY) |-> (out_wind_speed_o == '0))
    else $error("empty-table result with nonzero speed");

  // a write item leaves the sequencer idle
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_command_i == wsti_pkg::CMD_WRITE) |=>
    (state_q == ST_IDLE))
    else $error("write item started a query");

  // the product accumulator keeps its top bit clear between multiply steps
  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (acc_q[33] == 1'b0))
    else $error("multiply accumulator overflow");

endmodule

`default_nettype wire

[sim/wind_speed_table_interpolator_core_test.sv]
// self-checking testbench of the wind speed table interpolator core
`default_nettype none

module wind_speed_table_interpolator_core_test;

  localparam int unsigned DEPTH          = 64;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned TARGET_ITEMS   = 560;
  localparam int unsigned MAX_REPORTS    = 100;

  // one input item as offered on the input channel
  typedef struct packed {
    logic        command;
    logic [5:0]  point_index;
    logic [31:0] point_time;
    logic [31:0] point_speed;
    logic [31:0] query_time;
  } wind_item_t;

  // one expected result item
  typedef struct packed {
    logic [31:0] speed;
    logic        status;
  } speed_result_t;

  // clock, reset and block inputs
  logic               clk_i        = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_valid    = 1'b0;
  logic [1:0]         cfg_index    = '0;
  logic [31:0]        cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_command   = 1'b0;
  logic [5:0]         in_index     = '0;
  logic signed [31:0] in_ptime     = '0;
  logic signed [31:0] in_pspeed    = '0;
  logic signed [31:0] in_qtime     = '0;
  logic               out_stall    = 1'b0;

  // block outputs
  wire logic               cfg_ready_o;
  wire logic               in_stall_o;
  wire logic               out_valid_o;
  wire logic signed [31:0] out_wind_speed_o;
  wire logic               out_status_o;

  wind_speed_table_interpolator_core #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .in_command_i    (in_command),
    .in_point_index_i(in_index),
    .in_point_time_i (in_ptime),
    .in_point_speed_i(in_pspeed),
    .in_query_time_i (in_qtime),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .out_wind_speed_o(out_wind_speed_o),
    .out_status_o    (out_status_o)
  );

  always #2 clk_i = ~clk_i;

  // pending items, expected speeds and run counters
  wind_item_t    pending[$];
  speed_result_t speed_due[$];
  int unsigned   n_queued    = 0;
  int unsigned   n_accepted  = 0;
  int unsigned   n_queries   = 0;
  int unsigned   n_writes    = 0;
  int unsigned   n_results   = 0;
  int unsigned   n_errors    = 0;
  int unsigned   n_phases    = 0;
  int unsigned   hold_asked  = 0;
  int unsigned   hold_done   = 0;
  bit            calm        = 1'b0;

  // predicted configuration and table contents
  bit                 pred_mode   = 1'b0;
  logic [31:0]        pred_steady = '0;
  bit                 pred_cycle  = 1'b0;
  logic [6:0]         pred_count  = '0;
  logic signed [31:0] pred_time  [DEPTH];
  logic signed [31:0] pred_speed [DEPTH];

  // table as the stimulus side has written it
  logic signed [31:0] gen_time  [DEPTH];
  bit                 gen_written [DEPTH];

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_errors < MAX_REPORTS)
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // speed from the breakpoint table for n valid points, n >= 1
  function automatic logic [31:0] interp_speed(input logic signed [31:0] qt,
                                               input int unsigned n);
    longint            dur, tin, t, tl, tr, sl, sr, d, res;
    longint unsigned   mag, num, den;
    logic [127:0]      prod, quo, rem;
    int unsigned       i;
    dur = pred_time[n-1];
    tin = qt;
    if (n == 1) return pred_speed[0];
    // bring the time into the table range
    if (tin < 0 || dur <= 0) t = 0;
    else if (tin <= dur) t = tin;
    else if (!pred_cycle) t = dur;
    else t = tin % dur;
    if (t <= longint'(pred_time[0])) return pred_speed[0];
    if (t >= dur) return pred_speed[n-1];
    // left point is the one before the first later time
    i = 1;
    while (i < n - 1 && longint'(pred_time[i]) <= t) i++;
    tl = pred_time[i-1];
    tr = pred_time[i];
    sl = pred_speed[i-1];
    sr = pred_speed[i];
    d  = sr - sl;
    mag = (d < 0) ? -d : d;
    num = t - tl;
    den = tr - tl;
    // exact scaled step, rounded half away from zero
    prod = 128'(mag) * 128'(num);
    quo  = prod / 128'(den);
    rem  = prod % 128'(den);
    if ((rem << 1) >= 128'(den)) quo = quo + 1;
    res = (d < 0) ? sl - longint'(quo[63:0]) : sl + longint'(quo[63:0]);
    return res[31:0];
  endfunction

  // update the table or queue the expected speed of an accepted item
  task automatic predict_item(input wind_item_t it);
    speed_result_t r;
    int unsigned   n;
    if (it.command == wsti_pkg::CMD_WRITE) begin
      pred_time[it.point_index]  = it.point_time;
      pred_speed[it.point_index] = it.point_speed;
      n_writes++;
    end else begin
      n = (pred_count > DEPTH) ? DEPTH : pred_count;
      if (!pred_mode) begin
        r.speed  = pred_steady;
        r.status = wsti_pkg::STATUS_OK;
      end else if (n == 0) begin
        r.speed  = '0;
        r.status = wsti_pkg::STATUS_EMPTY;
      end else begin
        r.speed  = interp_speed(it.query_time, n);
        r.status = wsti_pkg::STATUS_OK;
      end
      speed_due.push_back(r);
      n_queries++;
    end
  endtask

  // input driver
  wind_item_t  cur_item;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_item(cur_item);
        n_accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          in_valid   <= 1'b1;
          in_command <= cur_item.command;
          in_index   <= cur_item.point_index;
          in_ptime   <= cur_item.point_time;
          in_pspeed  <= cur_item.point_speed;
          in_qtime   <= cur_item.query_time;
          gap_left = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  speed_result_t want;
  int unsigned   stall_left = 0;
  int unsigned   hold_left  = 0;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_results++;
        if (speed_due.size() == 0) begin
          report_mismatch("result with no query waiting", out_wind_speed_o, '0);
        end else begin
          want = speed_due.pop_front();
          if (out_wind_speed_o !== want.speed)
            report_mismatch("wind_speed", out_wind_speed_o, want.speed);
          if (out_status_o !== want.status)
            report_mismatch("status", 32'(out_status_o), 32'(want.status));
        end
        stall_left = draw_wait();
      end
      if (hold_done != hold_asked) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // configuration register write, only while idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      wsti_pkg::REG_TABLE_MODE:   pred_mode   = val[0];
      wsti_pkg::REG_STEADY_SPEED: pred_steady = val;
      wsti_pkg::REG_CYCLE_ENABLE: pred_cycle  = val[0];
      wsti_pkg::REG_POINT_COUNT:  pred_count  = val[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait until every item is taken and every result is in, then let the block drain
  task automatic settle();
    while (n_accepted != n_queued || speed_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_write(input logic [5:0] idx, input logic [31:0] tm,
                            input logic [31:0] sp);
    wind_item_t it;
    it.command     = wsti_pkg::CMD_WRITE;
    it.point_index = idx;
    it.point_time  = tm;
    it.point_speed = sp;
    it.query_time  = $urandom;
    gen_time[idx]    = tm;
    gen_written[idx] = 1'b1;
    pending.push_back(it);
    n_queued++;
  endtask

  task automatic push_query(input logic [31:0] qt);
    wind_item_t it;
    it.command     = wsti_pkg::CMD_QUERY;
    it.point_index = 6'($urandom);
    it.point_time  = $urandom;
    it.point_speed = $urandom;
    it.query_time  = qt;
    pending.push_back(it);
    n_queued++;
  endtask

  function automatic logic [31:0] clip_q16(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // query time aimed at the table edges, breakpoints, wrap and interior
  function automatic logic [31:0] gen_query_time(input int unsigned eff);
    longint          t0, dur, v;
    longint unsigned r64;
    t0  = gen_time[0];
    dur = (eff > 0) ? longint'(gen_time[eff-1]) : 0;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return (eff > 0) ? gen_time[$urandom_range(0, eff - 1)] : $urandom;
      2: begin
        v = (eff > 0) ? longint'(gen_time[$urandom_range(0, eff - 1)]) : 0;
        v = v + longint'($urandom_range(0, 2)) - 1;
      end
      3: begin
        case ($urandom_range(0, 2))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          default: v = -longint'($urandom_range(1, 65536));
        endcase
      end
      4: v = dur + longint'($urandom_range(1, 1 << 20));
      5: v = dur * longint'($urandom_range(1, 4)) + longint'($urandom_range(0, 65536));
      default: begin
        if (dur > t0) begin
          r64 = {$urandom, $urandom};
          v = t0 + longint'(r64 % longint'(dur - t0 + 1));
        end else begin
          return $urandom;
        end
      end
    endcase
    return clip_q16(v);
  endfunction

  // load entries 0 .. cnt-1 with a fresh table
  task automatic build_table(input int unsigned cnt);
    int unsigned style, step_max;
    bit          wild_speed;
    longint      t;
    logic [31:0] tm, sp;
    style      = $urandom_range(0, 9);
    wild_speed = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 2))
      0:       step_max = 16;
      1:       step_max = 32'h0004_0000;
      default: step_max = 32'h0100_0000;
    endcase
    t = longint'($urandom_range(0, 32'h6000_0000)) - 64'sd1073741824;
    // table that ends at or below zero
    if (style == 2) t = -longint'(cnt) * step_max - longint'($urandom_range(0, 1 << 20));
    for (int unsigned i = 0; i < cnt; i++) begin
      if (wild_speed) sp = i[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      else sp = $urandom;
      case (style)
        0: tm = clip_q16(-64'sd2147483648 +
                         (longint'(i) * 64'sd4294967295) / ((cnt > 1) ? cnt - 1 : 1));
        1: tm = $urandom;
        default: begin
          tm = t[31:0];
          t  = t + longint'($urandom_range(1, step_max));
        end
      endcase
      if (style == 2 && i == cnt - 1 && $urandom_range(0, 1)) tm = '0;
      push_write(i[5:0], tm, sp);
    end
  endtask

  // stimulus sequence
  initial begin : stimulus
    int unsigned count, eff, m, idx, r;
    bit          fresh;
    for (int i = 0; i < DEPTH; i++) begin
      gen_time[i]    = '0;
      gen_written[i] = 1'b0;
      pred_time[i]   = '0;
      pred_speed[i]  = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // steady mode at reset and at the speed extremes
    push_query(32'h8000_0000);
    settle();
    write_reg(wsti_pkg::REG_STEADY_SPEED, 32'h7FFF_FFFF);
    push_query(32'h7FFF_FFFF);
    settle();
    write_reg(wsti_pkg::REG_STEADY_SPEED, 32'h8000_0000);
    push_query(32'h0000_0000);
    settle();
    // empty table in table mode
    write_reg(wsti_pkg::REG_TABLE_MODE, 32'd1);
    push_query(32'h0005_0000);
    push_write(6'd0, 32'h0000_0000, 32'h8000_0000);
    push_write(6'd1, 32'h000A_0000, 32'h7FFF_FFFF);
    push_write(6'd2, 32'h0014_0000, 32'h0001_0000);
    push_write(6'd3, 32'h001E_0000, 32'hFFFF_8000);
    settle();
    // four points: negative time, interior, breakpoint, end and past the end
    write_reg(wsti_pkg::REG_POINT_COUNT, 32'd4);
    push_query(32'h8000_0000);
    push_query(32'h0005_0000);
    push_query(32'h000A_0000);
    push_query(32'h000F_0001);
    push_query(32'h0019_0000);
    push_query(32'h001E_0000);
    push_query(32'h7FFF_FFFF);
    settle();
    // wrap past the duration
    write_reg(wsti_pkg::REG_CYCLE_ENABLE, 32'd1);
    push_query(32'h002D_0000);
    push_query(32'h7FFF_FFFF);
    settle();
    // single point
    write_reg(wsti_pkg::REG_POINT_COUNT, 32'd1);
    push_query(32'h0005_0000);
    // duration not positive
    push_write(6'd0, 32'hFFFB_0000, 32'h0003_0000);
    push_write(6'd1, 32'hFFFF_0000, 32'h0007_0000);
    settle();
    write_reg(wsti_pkg::REG_POINT_COUNT, 32'd2);
    push_query(32'h0005_0000);

    // random settings, each with its table and a mix of queries and writes
    while (n_queued < TARGET_ITEMS) begin
      settle();
      n_phases++;
      r = $urandom_range(0, 9);
      case (r)
        0:       count = 0;
        1:       count = DEPTH;
        2:       count = $urandom_range(DEPTH + 1, 127);
        3:       count = $urandom_range(9, DEPTH - 1);
        default: count = $urandom_range(1, 8);
      endcase
      eff  = (count > DEPTH) ? DEPTH : count;
      calm = ($urandom_range(0, 3) == 0);
      write_reg(wsti_pkg::REG_TABLE_MODE, 32'($urandom_range(0, 3) != 0));
      write_reg(wsti_pkg::REG_CYCLE_ENABLE, 32'($urandom_range(0, 1)));
      write_reg(wsti_pkg::REG_POINT_COUNT, count);
      case ($urandom_range(0, 5))
        0:       write_reg(wsti_pkg::REG_STEADY_SPEED, 32'h7FFF_FFFF);
        1:       write_reg(wsti_pkg::REG_STEADY_SPEED, 32'h8000_0000);
        2:       write_reg(wsti_pkg::REG_STEADY_SPEED, 32'h0000_0000);
        default: write_reg(wsti_pkg::REG_STEADY_SPEED, $urandom);
      endcase
      // every entry below the count must be written before a query
      fresh = ($urandom_range(0, 1) == 0);
      for (int unsigned i = 0; i < eff; i++)
        if (!gen_written[i]) fresh = 1'b1;
      if (fresh) build_table(eff);
      m = $urandom_range(15, 50);
      for (int unsigned j = 0; j < m; j++) begin
        if ($urandom_range(0, 4) != 0) begin
          push_query(gen_query_time(eff));
        end else if (eff > 0 && $urandom_range(0, 9) < 7) begin
          idx = $urandom_range(0, eff - 1);
          push_write(idx[5:0], gen_time[idx], $urandom);
        end else begin
          push_write(6'($urandom_range(0, DEPTH - 1)), $urandom, $urandom);
        end
      end
      // long receiver hold-off while the sender keeps offering
      if (n_phases == 2 || n_phases == 6) hold_asked++;
    end

    settle();
    $display("covered %0d items: %0d queries and %0d writes over %0d random settings",
             n_accepted, n_queries, n_writes, n_phases);
    $display("checked %0d results with %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && speed_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
